// ===== rtl/sgpg_pkg.sv =====
// Shared types and constants for the stepper goal pulse generator.
`timescale 1ns / 1ps

package sgpg_pkg;

    localparam int unsigned ActionWidth = 3;
    localparam int unsigned PosWidth = 32;
    localparam int unsigned TickWidth = 16;
    localparam logic [TickWidth-1:0] HalfPeriodReset = 16'd5000;

    typedef enum logic [ActionWidth-1:0] {
        ACT_TICK     = 3'd0,
        ACT_SET_POS  = 3'd1,
        ACT_SET_GOAL = 3'd2,
        ACT_START    = 3'd3,
        ACT_STOP     = 3'd4
    } action_t;

    typedef struct packed {
        logic                       pulse;
        logic                       dir;
        logic signed [PosWidth-1:0] position;
        logic                       running;
        logic                       armed;
    } result_t;

endpackage

// ===== rtl/sgpg_core.sv =====
// Stepper state registers and the next-state logic for one command.
`timescale 1ns / 1ps

module sgpg_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 enable,
    input  logic [sgpg_pkg::ActionWidth-1:0]     action,
    input  logic signed [sgpg_pkg::PosWidth-1:0] value,
    input  logic [sgpg_pkg::TickWidth-1:0]       half_period,
    output sgpg_pkg::result_t                    result
);

    logic signed [sgpg_pkg::PosWidth-1:0] pos_reg;
    logic signed [sgpg_pkg::PosWidth-1:0] pos_next;
    logic signed [sgpg_pkg::PosWidth-1:0] goal_reg;
    logic signed [sgpg_pkg::PosWidth-1:0] goal_next;
    logic                                 run_reg;
    logic                                 run_next;
    logic                                 pulse_reg;
    logic                                 pulse_next;
    logic                                 dir_reg;
    logic                                 dir_next;
    logic                                 armed_reg;
    logic                                 armed_next;
    logic [sgpg_pkg::TickWidth-1:0]       cnt_reg;
    logic [sgpg_pkg::TickWidth-1:0]       cnt_next;

    logic [sgpg_pkg::TickWidth-1:0]       cnt_inc;
    logic signed [sgpg_pkg::PosWidth-1:0] pos_up;
    logic signed [sgpg_pkg::PosWidth-1:0] pos_down;
    logic                                 below_goal;
    logic                                 above_goal;
    logic                                 reach_goal;

    assign cnt_inc    = cnt_reg + {{(sgpg_pkg::TickWidth-1){1'b0}}, 1'b1};
    assign pos_up     = pos_reg + 32'sd1;
    assign pos_down   = pos_reg - 32'sd1;
    assign below_goal = pos_reg < goal_reg;
    assign above_goal = pos_reg > goal_reg;
    // After a step the position lands on the goal only when it was one step short of it.
    assign reach_goal = below_goal ? (pos_up == goal_reg)
                      : (above_goal ? (pos_down == goal_reg) : 1'b1);

    always_comb
    begin
        pos_next   = pos_reg;
        goal_next  = goal_reg;
        run_next   = run_reg;
        pulse_next = pulse_reg;
        dir_next   = dir_reg;
        armed_next = armed_reg;
        cnt_next   = cnt_reg;
        case (action)
            sgpg_pkg::ACT_TICK:
            begin
                if (armed_reg)
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= half_period)
                    begin
                        armed_next = 1'b0;
                        pulse_next = !pulse_reg;
                        if (pulse_reg)
                        begin
                            if (below_goal)
                            begin
                                pos_next = pos_up;
                                dir_next = 1'b0;
                            end
                            else if (above_goal)
                            begin
                                pos_next = pos_down;
                                dir_next = 1'b1;
                            end
                            if (run_reg && !reach_goal)
                            begin
                                cnt_next   = '0;
                                armed_next = 1'b1;
                            end
                        end
                        else
                        begin
                            cnt_next   = '0;
                            armed_next = 1'b1;
                        end
                    end
                end
            end
            sgpg_pkg::ACT_SET_POS:
            begin
                pos_next = value;
            end
            sgpg_pkg::ACT_SET_GOAL:
            begin
                goal_next = value;
                if (run_reg && (value != pos_reg))
                begin
                    cnt_next   = '0;
                    armed_next = 1'b1;
                end
            end
            sgpg_pkg::ACT_START:
            begin
                if (!run_reg)
                begin
                    run_next = 1'b1;
                    if (pos_reg != goal_reg)
                    begin
                        cnt_next   = '0;
                        armed_next = 1'b1;
                    end
                end
            end
            sgpg_pkg::ACT_STOP:
            begin
                run_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            goal_reg  <= '0;
            run_reg   <= 1'b0;
            pulse_reg <= 1'b0;
            dir_reg   <= 1'b0;
            armed_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (enable)
        begin
            pos_reg   <= pos_next;
            goal_reg  <= goal_next;
            run_reg   <= run_next;
            pulse_reg <= pulse_next;
            dir_reg   <= dir_next;
            armed_reg <= armed_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign result.pulse    = pulse_next;
    assign result.dir      = dir_next;
    assign result.position = pos_next;
    assign result.running  = run_next;
    assign result.armed    = armed_next;

endmodule

// ===== rtl/stepper_goal_pulse_generator.sv =====
// Top level of the stepper goal pulse generator: input, config and result registers.
//
// Channel  Direction  Handshake              Payload
// in       in         in_valid / in_ready    action, position_value
// out      out        out_valid / out_ready  pulse_level, direction_level, position_now,
//                                            is_running, timer_armed
// cfg      in         cfg_valid / cfg_ready  cfg_data (half period in ticks)
//
// Every command or tick is held in the input register until its result is registered in
// the result register, where the result is offered.
// One command is taken every cycle while the result side keeps draining.
// A stalled result holds the result register and the input register fills behind it.
// Reset clears the stepper state and sets the half period to 5000 ticks.
`timescale 1ns / 1ps

module stepper_goal_pulse_generator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [sgpg_pkg::ActionWidth-1:0]     action,
    input  logic signed [sgpg_pkg::PosWidth-1:0] position_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 pulse_level,
    output logic                                 direction_level,
    output logic signed [sgpg_pkg::PosWidth-1:0] position_now,
    output logic                                 is_running,
    output logic                                 timer_armed,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sgpg_pkg::TickWidth-1:0]       cfg_data
);

    logic                                 in_valid_reg;
    logic [sgpg_pkg::ActionWidth-1:0]     action_reg;
    logic signed [sgpg_pkg::PosWidth-1:0] value_reg;
    logic [sgpg_pkg::TickWidth-1:0]       half_period_reg;
    logic                                 out_valid_reg;
    sgpg_pkg::result_t                    result_reg;
    sgpg_pkg::result_t                    result_next;
    logic                                 advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            half_period_reg <= sgpg_pkg::HalfPeriodReset;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                half_period_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= action;
            value_reg  <= position_value;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    sgpg_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .enable      (advance),
        .action      (action_reg),
        .value       (value_reg),
        .half_period (half_period_reg),
        .result      (result_next)
    );

    assign out_valid       = out_valid_reg;
    assign pulse_level     = result_reg.pulse;
    assign direction_level = result_reg.dir;
    assign position_now    = result_reg.position;
    assign is_running      = result_reg.running;
    assign timer_armed     = result_reg.armed;

endmodule

// ===== tb/stepper_goal_pulse_generator_tb.sv =====
// Self-checking testbench for the stepper goal pulse generator with random commands and stalls.
`timescale 1ns / 1ps

module stepper_goal_pulse_generator_tb;

    localparam int MaxCode = (1 << sgpg_pkg::ActionWidth) - 1;
    localparam longint PosMax = (longint'(1) << (sgpg_pkg::PosWidth - 1)) - 1;
    localparam longint PosMin = -(longint'(1) << (sgpg_pkg::PosWidth - 1));
    localparam int LongHold = 48;
    localparam int WatchdogLimit = 2000;
    localparam int PhaseItems = 95;

    typedef struct {
        logic [sgpg_pkg::ActionWidth-1:0]     act;
        logic signed [sgpg_pkg::PosWidth-1:0] val;
    } stepper_cmd_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic [sgpg_pkg::ActionWidth-1:0]     action = '0;
    logic signed [sgpg_pkg::PosWidth-1:0] position_value = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic                                 pulse_level;
    logic                                 direction_level;
    logic signed [sgpg_pkg::PosWidth-1:0] position_now;
    logic                                 is_running;
    logic                                 timer_armed;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [sgpg_pkg::TickWidth-1:0]       cfg_data = sgpg_pkg::HalfPeriodReset;

    stepper_cmd_t      pending_cmds[$];
    sgpg_pkg::result_t expected_results[$];
    int                mismatches = 0;
    int                cmds_sent = 0;
    int                results_seen = 0;
    int                gap_left = 0;
    int                stall_left = 0;
    int                hold_left = 0;
    int                quiet_cycles = 0;
    int unsigned       phase_halves[12] = '{1, 2, 0, 3, 1, 40, 2, 5, 65535, 1, 3, 2};

    logic signed [sgpg_pkg::PosWidth-1:0] stp_position = '0;
    logic signed [sgpg_pkg::PosWidth-1:0] stp_goal = '0;
    logic                                 stp_running = 1'b0;
    logic                                 stp_pulse = 1'b0;
    logic                                 stp_dir = 1'b0;
    logic                                 stp_armed = 1'b0;
    logic [sgpg_pkg::TickWidth-1:0]       stp_ticks = '0;
    logic [sgpg_pkg::TickWidth-1:0]       stp_half = sgpg_pkg::HalfPeriodReset;

    stepper_goal_pulse_generator uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .position_value (position_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pulse_level    (pulse_level),
        .direction_level(direction_level),
        .position_now   (position_now),
        .is_running     (is_running),
        .timer_armed    (timer_armed),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic void arm_step_timer();
        stp_ticks = '0;
        stp_armed = 1'b1;
    endfunction

    function automatic sgpg_pkg::result_t advance_stepper(
        input logic [sgpg_pkg::ActionWidth-1:0]     act,
        input logic signed [sgpg_pkg::PosWidth-1:0] val);
        sgpg_pkg::result_t r;
        case (act)
            sgpg_pkg::ACT_TICK:
            begin
                if (stp_armed)
                begin
                    stp_ticks = stp_ticks + 1'b1;
                    if (stp_ticks >= stp_half)
                    begin
                        stp_armed = 1'b0;
                        stp_pulse = ~stp_pulse;
                        if (stp_pulse)
                            arm_step_timer();
                        else
                        begin
                            if (stp_position < stp_goal)
                            begin
                                stp_position = stp_position + 1;
                                stp_dir = 1'b0;
                            end
                            else if (stp_position > stp_goal)
                            begin
                                stp_position = stp_position - 1;
                                stp_dir = 1'b1;
                            end
                            if (stp_running && stp_position != stp_goal)
                                arm_step_timer();
                        end
                    end
                end
            end
            sgpg_pkg::ACT_SET_POS:
                stp_position = val;
            sgpg_pkg::ACT_SET_GOAL:
            begin
                stp_goal = val;
                if (stp_running && val != stp_position)
                    arm_step_timer();
            end
            sgpg_pkg::ACT_START:
            begin
                if (!stp_running)
                begin
                    stp_running = 1'b1;
                    if (stp_position != stp_goal)
                        arm_step_timer();
                end
            end
            sgpg_pkg::ACT_STOP:
                stp_running = 1'b0;
            default:
                ;
        endcase
        r.pulse = stp_pulse;
        r.dir = stp_dir;
        r.position = stp_position;
        r.running = stp_running;
        r.armed = stp_armed;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : command_driver
        stepper_cmd_t next_cmd;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= sgpg_pkg::ACT_TICK;
            position_value <= '0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(advance_stepper(action, position_value));
                cmds_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    next_cmd = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    action <= next_cmd.act;
                    position_value <= next_cmd.val;
                    gap_left = ((cmds_sent / 64) % 3 == 0) ? 0 : $urandom_range(0, 5);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        sgpg_pkg::result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing outstanding", position_now, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (pulse_level !== want.pulse)
                        report_mismatch("pulse_level", pulse_level, want.pulse);
                    if (direction_level !== want.dir)
                        report_mismatch("direction_level", direction_level, want.dir);
                    if (position_now !== want.position)
                        report_mismatch("position_now", position_now, want.position);
                    if (is_running !== want.running)
                        report_mismatch("is_running", is_running, want.running);
                    if (timer_armed !== want.armed)
                        report_mismatch("timer_armed", timer_armed, want.armed);
                end
                results_seen++;
                stall_left = ((results_seen / 50) % 3 == 0) ? 0 : $urandom_range(0, 5);
                // Every so often the receiver holds off long enough for the block to fill.
                if (results_seen % 400 == 0)
                    hold_left = LongHold;
            end
            else
            begin
                if (stall_left > 0)
                    stall_left--;
                if (hold_left > 0)
                    hold_left--;
            end
            out_ready <= (stall_left == 0 && hold_left == 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WatchdogLimit)
        begin
            $display("stepper_goal_pulse_generator_tb: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic add_cmd(input int act, input longint val);
        stepper_cmd_t c;
        c.act = act[sgpg_pkg::ActionWidth-1:0];
        c.val = val[sgpg_pkg::PosWidth-1:0];
        pending_cmds.push_back(c);
    endtask

    function automatic longint pick_position();
        case ($urandom_range(0, 3))
            0: return longint'($signed($urandom));
            1: return PosMax - longint'($urandom_range(0, 8));
            2: return PosMin + longint'($urandom_range(0, 8));
            default: return longint'($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    task automatic queue_step_run(input int unsigned half);
        longint from_pos;
        longint to_pos;
        longint span;
        int     n;
        int     eff_half;
        from_pos = pick_position();
        to_pos = from_pos + (int'($urandom_range(0, 12)) - 6);
        if (to_pos > PosMax)
            to_pos = PosMax;
        if (to_pos < PosMin)
            to_pos = PosMin;
        span = (to_pos > from_pos) ? to_pos - from_pos : from_pos - to_pos;
        eff_half = (half == 0) ? 1 : int'(half);
        n = (2 * int'(span) + 1) * eff_half + int'($urandom_range(0, 4));
        if (n > 150)
            n = 150;
        add_cmd(sgpg_pkg::ACT_SET_POS, from_pos);
        add_cmd(sgpg_pkg::ACT_SET_GOAL, to_pos);
        add_cmd(sgpg_pkg::ACT_START, $urandom);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                add_cmd($urandom_range(0, MaxCode), $urandom);
            else
                add_cmd(sgpg_pkg::ACT_TICK, $urandom);
        end
        add_cmd(sgpg_pkg::ACT_STOP, $urandom);
    endtask

    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_half_period(input logic [sgpg_pkg::TickWidth-1:0] ticks);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= ticks;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        stp_half = ticks;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset half period: idle tick, unused codes, a start while running and a stop.
        add_cmd(sgpg_pkg::ACT_TICK, 0);
        for (int c = int'(sgpg_pkg::ACT_STOP) + 1; c <= MaxCode; c++)
            add_cmd(c, pick_position());
        add_cmd(sgpg_pkg::ACT_SET_POS, PosMax);
        add_cmd(sgpg_pkg::ACT_SET_GOAL, PosMin);
        add_cmd(sgpg_pkg::ACT_START, 0);
        add_cmd(sgpg_pkg::ACT_START, -1);
        add_cmd(sgpg_pkg::ACT_TICK, PosMax);
        add_cmd(sgpg_pkg::ACT_STOP, PosMin);
        wait_until_drained();

        // A zero half period expires on the first tick; walk the position ends.
        write_half_period('0);
        add_cmd(sgpg_pkg::ACT_SET_POS, PosMax - 1);
        add_cmd(sgpg_pkg::ACT_START, 0);
        add_cmd(sgpg_pkg::ACT_SET_GOAL, PosMax);
        add_cmd(sgpg_pkg::ACT_TICK, 0);
        add_cmd(sgpg_pkg::ACT_TICK, 0);
        add_cmd(sgpg_pkg::ACT_TICK, 0);
        add_cmd(sgpg_pkg::ACT_SET_POS, PosMin + 1);
        add_cmd(sgpg_pkg::ACT_SET_GOAL, PosMin);
        add_cmd(sgpg_pkg::ACT_TICK, 0);
        add_cmd(sgpg_pkg::ACT_STOP, 0);
        add_cmd(sgpg_pkg::ACT_TICK, 0);
        add_cmd(sgpg_pkg::ACT_SET_GOAL, 3);
        add_cmd(sgpg_pkg::ACT_START, 0);
        add_cmd(sgpg_pkg::ACT_STOP, 0);
        add_cmd(sgpg_pkg::ACT_TICK, 0);
        add_cmd(sgpg_pkg::ACT_START, 0);
        add_cmd(sgpg_pkg::ACT_SET_POS, 3);
        add_cmd(sgpg_pkg::ACT_TICK, 0);
        // Steps from one end of the range with the goal at the far end.
        add_cmd(sgpg_pkg::ACT_SET_POS, PosMin);
        add_cmd(sgpg_pkg::ACT_SET_GOAL, PosMax);
        repeat (3) add_cmd(sgpg_pkg::ACT_TICK, 0);
        add_cmd(sgpg_pkg::ACT_SET_POS, PosMax);
        add_cmd(sgpg_pkg::ACT_SET_GOAL, PosMin);
        repeat (3) add_cmd(sgpg_pkg::ACT_TICK, 0);
        add_cmd(sgpg_pkg::ACT_STOP, 0);
        wait_until_drained();

        foreach (phase_halves[p])
        begin
            write_half_period(phase_halves[p][sgpg_pkg::TickWidth-1:0]);
            while (pending_cmds.size() < PhaseItems)
            begin
                if ($urandom_range(0, 7) == 0)
                    repeat (8) add_cmd($urandom_range(0, MaxCode), $urandom);
                else
                    queue_step_run(phase_halves[p]);
            end
            wait_until_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("stepper_goal_pulse_generator_tb: PASS");
        else
            $display("stepper_goal_pulse_generator_tb: FAIL");
        $finish;
    end

endmodule

// ===== stepper_goal_pulse_generator.f =====
rtl/sgpg_pkg.sv
rtl/sgpg_core.sv
rtl/stepper_goal_pulse_generator.sv
tb/stepper_goal_pulse_generator_tb.sv
